>>> hw/rtl/crcpac_pkg.sv
package crcpac_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam int          CRC_BYTES    = 4;
    localparam int          JOBQ_DEPTH   = 2;
    localparam int          JOBQ_AW      = $clog2(JOBQ_DEPTH);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ECHO    = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] crc;
        t_status     status;
        logic [7:0]  len;
    } t_job;

    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/crcpac_front.sv
module crcpac_front #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_check_mode,
    input  logic              i_push,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic              i_q_full,
    output logic              o_job_valid,
    output crcpac_pkg::t_job  o_job
);
    import crcpac_pkg::*;

    localparam int CW = $clog2(MAX_PACKET_BYTES + 2);

    logic              r_mode;
    logic              n_mode;
    logic [31:0]       r_crc;
    logic [31:0]       n_crc;
    logic [7:0]        r_tail [CRC_BYTES];
    logic [7:0]        n_tail [CRC_BYTES];
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     n_cnt;
    logic [CW-1:0]     cnt_inc;
    logic [CW-1:0]     len_wide;
    logic [31:0]       crc_gen;
    logic [31:0]       crc_chk;
    logic [31:0]       got;
    logic              accept;
    t_status           status;
    logic [7:0]        len;

    assign accept = i_push && !i_q_full;

    always_comb begin
        cnt_inc  = (r_cnt <= CW'(MAX_PACKET_BYTES)) ? r_cnt + CW'(1) : r_cnt;
        crc_gen  = crc_feed(r_crc, i_data_byte);
        crc_chk  = (cnt_inc > CW'(4)) ? crc_feed(r_crc, r_tail[0]) : r_crc;
        got      = {r_tail[1], r_tail[2], r_tail[3], i_data_byte};
        len_wide = cnt_inc - CW'(4);
        len      = 8'd0;
        if (cnt_inc < CW'(4)) begin
            status = ST_SHORT;
        end else if (cnt_inc > CW'(MAX_PACKET_BYTES)) begin
            status = ST_MISMATCH;
        end else if (got == ~crc_chk) begin
            status = ST_OK;
            len    = (32'(len_wide) > 32'd255) ? 8'hFF : 8'(len_wide);
        end else begin
            status = ST_MISMATCH;
        end
    end

    always_comb begin
        o_job_valid = accept && (!r_mode || i_last_byte);
        if (r_mode) begin
            o_job.kind   = KIND_VERDICT;
            o_job.data   = 8'd0;
            o_job.last   = 1'b1;
            o_job.crc    = 32'd0;
            o_job.status = status;
            o_job.len    = len;
        end else begin
            o_job.kind   = KIND_ECHO;
            o_job.data   = i_data_byte;
            o_job.last   = i_last_byte;
            o_job.crc    = ~crc_gen;
            o_job.status = ST_OK;
            o_job.len    = 8'd0;
        end
    end

    always_comb begin
        n_mode = r_mode;
        n_crc  = r_crc;
        n_tail = r_tail;
        n_cnt  = r_cnt;
        if (i_cfg_valid || (accept && i_last_byte)) begin
            if (i_cfg_valid) begin
                n_mode = i_cfg_check_mode;
            end
            n_crc = CRC_INIT;
            n_cnt = '0;
            for (int i = 0; i < CRC_BYTES; i++) begin
                n_tail[i] = 8'd0;
            end
        end else if (accept) begin
            n_cnt = cnt_inc;
            if (r_mode) begin
                n_crc = crc_chk;
                for (int i = 0; i < CRC_BYTES - 1; i++) begin
                    n_tail[i] = r_tail[i+1];
                end
                n_tail[CRC_BYTES-1] = i_data_byte;
            end else begin
                n_crc = crc_gen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_crc  <= CRC_INIT;
            r_cnt  <= '0;
            for (int i = 0; i < CRC_BYTES; i++) begin
                r_tail[i] <= 8'd0;
            end
        end else begin
            r_mode <= n_mode;
            r_crc  <= n_crc;
            r_cnt  <= n_cnt;
            r_tail <= n_tail;
        end
    end

endmodule

>>> hw/rtl/crcpac_jobq.sv
module crcpac_jobq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  crcpac_pkg::t_job  i_job,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output crcpac_pkg::t_job  o_job
);
    import crcpac_pkg::*;

    localparam int CNTW = $clog2(JOBQ_DEPTH + 1);

    t_job               r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0] r_wr;
    logic [JOBQ_AW-1:0] r_rd;
    logic [CNTW-1:0]    r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == CNTW'(JOBQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : r_wr + JOBQ_AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == JOBQ_AW'(JOBQ_DEPTH - 1)) ? '0 : r_rd + JOBQ_AW'(1);
            end
            r_cnt <= r_cnt + CNTW'(do_push) - CNTW'(do_pop);
        end
    end

endmodule

>>> hw/rtl/crcpac_back.sv
module crcpac_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  crcpac_pkg::t_job  i_job,
    output logic              o_job_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last,
    output logic [1:0]        o_check_status,
    output logic [7:0]        o_payload_length
);
    import crcpac_pkg::*;

    localparam int LW = $clog2(CRC_BYTES + 1);

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;
    t_status       r_out_status;
    logic [7:0]    r_out_len;
    logic [31:0]   r_crc_sh;
    logic [LW-1:0] r_left;
    logic          slot_free;
    logic          crc_busy;
    logic          take_job;
    logic          emit_crc;

    assign slot_free = !r_out_valid || i_pop;
    assign crc_busy  = (r_left != '0);
    assign take_job  = slot_free && !crc_busy && i_job_valid;
    assign emit_crc  = slot_free && crc_busy;
    assign o_job_pop = take_job;

    assign o_empty          = !r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_last       = r_out_last;
    assign o_check_status   = r_out_status;
    assign o_payload_length = r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            if (emit_crc || take_job) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (emit_crc) begin
                r_left <= r_left - LW'(1);
            end else if (take_job && i_job.kind == KIND_ECHO && i_job.last) begin
                r_left <= LW'(CRC_BYTES);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_crc) begin
            r_out_byte   <= r_crc_sh[31:24];
            r_out_last   <= (r_left == LW'(1));
            r_out_status <= ST_OK;
            r_out_len    <= 8'd0;
            r_crc_sh     <= {r_crc_sh[23:0], 8'd0};
        end else if (take_job) begin
            r_out_byte   <= i_job.data;
            r_out_last   <= (i_job.kind == KIND_VERDICT);
            r_out_status <= i_job.status;
            r_out_len    <= i_job.len;
            r_crc_sh     <= i_job.crc;
        end
    end

endmodule

>>> hw/rtl/crc32_packet_append_check.sv
// CRC-32 (reflected, poly 0xEDB88320, preset all ones, inverted result) packet
// appender and checker with queue-style ports. With check mode 0 every byte is
// echoed and the last byte is followed by four CRC bytes, most significant first;
// with check mode 1 the trailing four bytes are compared against the CRC of the
// bytes before them and the last byte yields one verdict word (status, payload
// length). Input takes one byte per cycle while full is low; a byte's first
// result passes the job queue and then the output register. The result side emits
// one word per cycle while pop is high, so each generate-mode packet end occupies
// it for the last byte and four CRC words; the two-deep job queue between front
// and back fills while CRC words go out, and back-to-back input sees full per
// packet end. Full also rises when pop stays low and the queue holds two jobs.
// Writing check mode restarts the packet in progress; o_cfg_ready is always high.
module crc32_packet_append_check #(
    parameter int MAX_PACKET_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_check_mode,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic [1:0] o_check_status,
    output logic [7:0] o_payload_length
);
    import crcpac_pkg::*;

    t_job front_job;
    t_job q_job;
    logic front_job_valid;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    crcpac_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_check_mode (i_cfg_check_mode),
        .i_push           (push),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_q_full         (q_full),
        .o_job_valid      (front_job_valid),
        .o_job            (front_job)
    );

    crcpac_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_job_valid),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    crcpac_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (q_valid),
        .i_job            (q_job),
        .o_job_pop        (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_out_byte       (o_out_byte),
        .o_out_last       (o_out_last),
        .o_check_status   (o_check_status),
        .o_payload_length (o_payload_length)
    );

endmodule

>>> hw/rtl/crcpac_checker.sv
module crcpac_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic [1:0] o_check_status,
    input logic [7:0] o_payload_length
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue flags not cleared by reset");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_out_last)
                              && $stable(o_check_status) && $stable(o_payload_length)))
        else $error("waiting word changed before pop");

    a_bad_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_check_status != 2'd0) |-> (o_out_last && o_payload_length == 8'd0
                                                && o_out_byte == 8'd0))
        else $error("failed verdict word malformed");

    a_data_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out_byte != 8'd0) |-> (o_check_status == 2'd0
                                            && o_payload_length == 8'd0))
        else $error("data word carries verdict fields");

endmodule

bind crc32_packet_append_check crcpac_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_out_byte       (o_out_byte),
    .o_out_last       (o_out_last),
    .o_check_status   (o_check_status),
    .o_payload_length (o_payload_length)
);
